### sv/ntsc_palette_to_rgb_top_macros.svh
// Assertion macros for the NTSC palette converter top level.
// Expects clk_i and rst_ni in the including scope.
`ifndef NTSC_PALETTE_TO_RGB_TOP_MACROS_SVH
`define NTSC_PALETTE_TO_RGB_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NPAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NPAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/npal_pkg.sv
// Shared types, tables and constants for the NTSC palette converter.
// No dependencies; used by npal_matrix, npal_scale and the top level.
`timescale 1ns / 1ps

package npal_pkg;

  localparam int CHANNEL_BITS_DEF = 16;
  localparam int LEVEL_W          = 16;
  localparam int CODE_W           = 8;
  localparam int ACC_W            = 28;
  localparam int ONE_W            = 26;
  localparam int SCALE_SHIFT      = 16;
  localparam int RECIP_W          = 27;
  localparam int RECIP_SHIFT      = 36;
  localparam int RECIP            = 68719477;
  localparam int MATRIX_ONE       = 65536000;
  localparam int MATRIX_HALF      = 32768000;

  localparam longint LADDER_TOTAL_NUM = 182373;
  localparam longint LADDER_SETUP     = 14787;
  localparam longint LUMA_UNIT        = 65536;
  localparam longint MATRIX_SCALE     = 1000;
  localparam int LADDER_WEIGHT [4] = '{340, 663, 1326, 2600};

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [17:0]      q216_t;
  typedef acc_t                    luma_tab_t [16];

  typedef struct packed {
    acc_t r;
    acc_t g;
    acc_t b;
  } rgb_acc_t;

  typedef struct packed {
    logic load_z;
    logic load_p;
  } scale_ctl_t;

  localparam acc_t MAT_RI = 28'sd956;
  localparam acc_t MAT_RQ = 28'sd621;
  localparam acc_t MAT_GI = 28'sd272;
  localparam acc_t MAT_GQ = 28'sd647;
  localparam acc_t MAT_BI = 28'sd1106;
  localparam acc_t MAT_BQ = 28'sd1703;

  localparam q216_t CHROMA_I [16] = '{
    18'sd0, 18'sd7139, 18'sd10993, 18'sd12946, 18'sd12661, 18'sd10186, 18'sd5951, 18'sd686,
    -18'sd4697, -18'sd9268, -18'sd12237, -18'sd13089, -18'sd11679, -18'sd8249, -18'sd3392,
    18'sd2050
  };

  localparam q216_t CHROMA_Q [16] = '{
    18'sd0, -18'sd10993, -18'sd7139, -18'sd2050, 18'sd3392, 18'sd8249, 18'sd11679,
    18'sd13089, 18'sd12237, 18'sd9268, 18'sd4697, -18'sd686, -18'sd5951, -18'sd10186,
    -18'sd12661, -18'sd12946
  };

  // Luma in Q2.16, rounded half away from zero, prescaled by the matrix unit.
  function automatic luma_tab_t build_luma_table();
    luma_tab_t t;
    int        c;
    int        b;
    longint    w;
    longint    n;
    longint    r;
    for (c = 0; c < 16; c++) begin
      w = 0;
      for (b = 0; b < 4; b++) begin
        if (((c >> b) & 1) != 0) begin
          w = w + LADDER_WEIGHT[b];
        end
      end
      n = 40 * w - LADDER_SETUP;
      if (n >= 0) begin
        r = (n * LUMA_UNIT + LADDER_TOTAL_NUM / 2) / LADDER_TOTAL_NUM;
      end else begin
        r = -(((-n) * LUMA_UNIT + LADDER_TOTAL_NUM / 2) / LADDER_TOTAL_NUM);
      end
      t[c] = acc_t'(r * MATRIX_SCALE);
    end
    return t;
  endfunction

  localparam luma_tab_t LUMA_TABLE = build_luma_table();

endpackage

### sv/ntsc_palette_to_rgb_top.sv
// NTSC palette code to RGB converter, top level with handshake pipeline.
// Four stages (input, matrix, clamp, reciprocal) register code_q, acc_q,
// z_q and prod_q; one code per cycle when out_ready_i does not stall.
// Stalls back up stage by stage; bubbles are squeezed out.
// Reset (rst_ni low, asynchronous) clears all stage valids; no clearing pass.
// Depends on npal_pkg, npal_matrix, npal_scale and the assertion macro header.
`timescale 1ns / 1ps
`include "ntsc_palette_to_rgb_top_macros.svh"

module ntsc_palette_to_rgb_top #(
  parameter int CHANNEL_BITS = npal_pkg::CHANNEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [npal_pkg::CODE_W-1:0]  color_code_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [npal_pkg::LEVEL_W-1:0] red_level_o,
  output logic [npal_pkg::LEVEL_W-1:0] green_level_o,
  output logic [npal_pkg::LEVEL_W-1:0] blue_level_o
);

  localparam logic [npal_pkg::LEVEL_W-1:0] FULL_SCALE =
    npal_pkg::LEVEL_W'((64'd1 << CHANNEL_BITS) - 64'd1);

  logic                        in_v_q;
  logic                        s1_v_q;
  logic                        z_v_q;
  logic                        p_v_q;
  logic [npal_pkg::CODE_W-1:0] code_q;
  npal_pkg::rgb_acc_t          acc_d;
  npal_pkg::rgb_acc_t          acc_q;
  logic                        rdy_p;
  logic                        rdy_z;
  logic                        rdy_s1;
  npal_pkg::scale_ctl_t        ctl;

  assign rdy_p      = !p_v_q || out_ready_i;
  assign rdy_z      = !z_v_q || rdy_p;
  assign rdy_s1     = !s1_v_q || rdy_z;
  assign in_ready_o = !in_v_q || rdy_s1;
  assign out_valid_o = p_v_q;

  assign ctl.load_z = rdy_z && s1_v_q;
  assign ctl.load_p = rdy_p && z_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      z_v_q  <= 1'b0;
      p_v_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (rdy_s1) begin
        s1_v_q <= in_v_q;
      end
      if (rdy_z) begin
        z_v_q <= s1_v_q;
      end
      if (rdy_p) begin
        p_v_q <= z_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      code_q <= color_code_i;
    end
    if (rdy_s1 && in_v_q) begin
      acc_q <= acc_d;
    end
  end

  npal_matrix u_matrix (
    .code_i (code_q),
    .acc_o  (acc_d)
  );

  npal_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_r (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .acc_i   (acc_q.r),
    .level_o (red_level_o)
  );

  npal_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_g (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .acc_i   (acc_q.g),
    .level_o (green_level_o)
  );

  npal_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_b (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .acc_i   (acc_q.b),
    .level_o (blue_level_o)
  );

  `NPAL_ASSERT_NOW(a_stall_full, !in_ready_o, in_v_q && s1_v_q && z_v_q && p_v_q && !out_ready_i, "input stalled with a bubble in the pipeline")
  `NPAL_ASSERT_NEXT(a_grey_hue, rdy_s1 && in_v_q && (code_q[7:4] == 4'd0), (acc_q.r == acc_q.g) && (acc_q.g == acc_q.b), "hue zero beat produced chroma")
  `NPAL_ASSERT_NOW(a_full_scale, out_valid_o, (red_level_o <= FULL_SCALE) && (green_level_o <= FULL_SCALE) && (blue_level_o <= FULL_SCALE), "output level above full scale")
  `NPAL_ASSERT_NEXT(a_advance, in_v_q && rdy_s1, s1_v_q, "beat lost between input and matrix stage")

endmodule

### sv/npal_matrix.sv
// Palette code to YIQ table lookup and fixed-point YIQ to RGB matrix.
// Depends on npal_pkg.
`timescale 1ns / 1ps

module npal_matrix (
  input  logic [npal_pkg::CODE_W-1:0] code_i,
  output npal_pkg::rgb_acc_t          acc_o
);

  npal_pkg::acc_t y;
  npal_pkg::acc_t ci;
  npal_pkg::acc_t cq;

  always_comb begin
    y  = npal_pkg::LUMA_TABLE[code_i[3:0]];
    ci = npal_pkg::acc_t'(npal_pkg::CHROMA_I[code_i[7:4]]);
    cq = npal_pkg::acc_t'(npal_pkg::CHROMA_Q[code_i[7:4]]);
    acc_o.r = y + ci * npal_pkg::MAT_RI + cq * npal_pkg::MAT_RQ;
    acc_o.g = y - ci * npal_pkg::MAT_GI - cq * npal_pkg::MAT_GQ;
    acc_o.b = y - ci * npal_pkg::MAT_BI + cq * npal_pkg::MAT_BQ;
  end

endmodule

### sv/npal_scale.sv
// One channel: clamp the matrix sum, scale to full range and round.
// Two register stages; divide by 1000 via exact reciprocal multiply. Depends on npal_pkg.
`timescale 1ns / 1ps

module npal_scale #(
  parameter int CHANNEL_BITS = npal_pkg::CHANNEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  npal_pkg::scale_ctl_t         ctl_i,
  input  npal_pkg::acc_t               acc_i,
  output logic [npal_pkg::LEVEL_W-1:0] level_o
);

  localparam int XW = npal_pkg::ONE_W + CHANNEL_BITS;
  localparam int ZW = XW - npal_pkg::SCALE_SHIFT;
  localparam int PW = ZW + npal_pkg::RECIP_W;

  logic [npal_pkg::ONE_W-1:0] clamp;
  logic [XW-1:0]              x;
  logic [ZW-1:0]              z_d;
  logic [ZW-1:0]              z_q;
  logic [PW-1:0]              prod_d;
  logic [PW-1:0]              prod_q;

  always_comb begin
    priority if (acc_i < 0) begin
      clamp = '0;
    end else if (acc_i > npal_pkg::acc_t'(npal_pkg::MATRIX_ONE)) begin
      clamp = npal_pkg::ONE_W'(npal_pkg::MATRIX_ONE);
    end else begin
      clamp = acc_i[npal_pkg::ONE_W-1:0];
    end
    x   = (XW'(clamp) << CHANNEL_BITS) - XW'(clamp) + XW'(npal_pkg::MATRIX_HALF);
    z_d = x[XW-1:npal_pkg::SCALE_SHIFT];
  end

  assign prod_d = PW'(z_q) * PW'(npal_pkg::RECIP);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_z) begin
      z_q <= z_d;
    end
    if (ctl_i.load_p) begin
      prod_q <= prod_d;
    end
  end

  assign level_o = npal_pkg::LEVEL_W'(prod_q[PW-1:npal_pkg::RECIP_SHIFT]);

endmodule
